@@ hdl/lgfd_pkg.sv @@
// lgfd_pkg: shared types, grid and waveform constants, and the color palette
// for the led grid frame driver
// no dependencies
package lgfd_pkg;

	// grid and waveform geometry
	localparam int GRID_ROWS     = 20;
	localparam int GRID_COLS     = 10;
	localparam int HIGH_TICKS    = 3;
	localparam int DATA_TICKS    = 4;
	localparam int LOW_TICKS     = 4;
	localparam int CELL_COUNT    = GRID_ROWS * GRID_COLS;
	localparam int FRAME_LEN     = CELL_COUNT + 1;
	localparam int BIT_TICKS     = HIGH_TICKS + DATA_TICKS + LOW_TICKS;
	localparam int BITS_PER_CELL = 24;

	// derived widths
	localparam int ADDR_W  = $clog2(FRAME_LEN);
	localparam int ROW_W   = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
	localparam int COL_W   = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
	localparam int PHASE_W = $clog2(BIT_TICKS);
	localparam int BIT_W   = $clog2(BITS_PER_CELL);

	localparam logic [7:0] BRIGHTNESS_RESET = 8'd20;

	// item kinds
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// cell color codes
	localparam logic [7:0] CODE_BLACK   = 8'd0;
	localparam logic [7:0] CODE_RED     = 8'd1;
	localparam logic [7:0] CODE_GREEN   = 8'd2;
	localparam logic [7:0] CODE_BLUE    = 8'd3;
	localparam logic [7:0] CODE_WHITE   = 8'd4;
	localparam logic [7:0] CODE_MAGENTA = 8'd5;
	localparam logic [7:0] CODE_YELLOW  = 8'd6;
	localparam logic [7:0] CODE_CYAN    = 8'd7;

	// color channel order on the wire
	localparam logic [1:0] CHAN_GREEN = 2'd0;
	localparam logic [1:0] CHAN_RED   = 2'd1;
	localparam logic [1:0] CHAN_BLUE  = 2'd2;

	typedef struct packed {
		logic       kind;
		logic [7:0] frame_byte;
	} item_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic frame_done;
		logic byte_dropped;
	} result_t;

	// channel enables of a code, ordered green, red, blue
	typedef struct packed {
		logic g;
		logic r;
		logic b;
	} chan_en_t;

	function automatic chan_en_t palette(input logic [7:0] code);
		chan_en_t en;
		en = '0;
		unique case (code)
			CODE_BLACK:   en = '0;
			CODE_RED:     en.r = 1'b1;
			CODE_GREEN:   en.g = 1'b1;
			CODE_BLUE:    en.b = 1'b1;
			CODE_WHITE:   en = '1;
			CODE_MAGENTA: begin
				en.r = 1'b1;
				en.b = 1'b1;
			end
			CODE_YELLOW: begin
				en.r = 1'b1;
				en.g = 1'b1;
			end
			CODE_CYAN: begin
				en.g = 1'b1;
				en.b = 1'b1;
			end
			default:      en.b = 1'b1;
		endcase
		return en;
	endfunction

endpackage

@@ hdl/lgfd_ram.sv @@
// lgfd_ram: generic simple dual-port ram, one write port and one registered read port
// read during write to the same address returns the old contents
// no dependencies
module lgfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/led_grid_frame_driver.sv @@
// led_grid_frame_driver: collects a frame of cell codes into a ram and plays it out
// as a one-wire led waveform, one phase per tick transaction
// depends on lgfd_pkg and lgfd_ram
// each result is registered: it sits in an output register the cycle after acceptance
// throughput: one transaction per cycle while item_ready is high; a loaded cell code
//   passes ram rdata and code_q, and is first needed after its first bit's high phase
// reset: control state, counters and brightness (to 20) clear asynchronously;
//   the frame ram is not cleared and is always fully written before it is read
module led_grid_frame_driver
	import lgfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  item_t      item,
	output logic       result_valid,
	input  logic       result_ready,
	output result_t    result,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	// control state
	logic [7:0]         brightness_q;
	logic               emit_q;
	logic [ADDR_W-1:0]  wpos_q;
	logic [PHASE_W-1:0] phase_q;
	logic [BIT_W-1:0]   bit_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [ADDR_W-1:0]  addr_q;
	logic               load_s1;
	logic               fwd_s1;
	logic               out_valid_q;

	// payload state
	logic [7:0]         code_q;
	logic [7:0]         cell_bright_q;
	logic [7:0]         fwd_data_s1;
	result_t            out_q;

	// ram ports
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [7:0]         ram_rdata;

	logic               accept;
	logic               byte_ok;
	logic               last_byte;
	logic               tick_act;
	logic               bit_end;
	logic               cell_end;
	logic               last_cell;
	logic               frame_end;
	logic               next_load;
	logic               col_end;
	logic [ADDR_W-1:0]  next_addr;
	logic               data_bit;
	logic               level;
	chan_en_t           en;
	logic               chan_on;
	result_t            res;

	lgfd_ram #(
		.WIDTH(8),
		.DEPTH(FRAME_LEN)
	) u_frame_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wpos_q),
		.wdata(item.frame_byte),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// handshake, the output register frees up when taken
	assign item_ready   = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign accept       = item_valid && item_ready;

	// event decode
	assign byte_ok   = accept && (item.kind == KIND_BYTE) && !emit_q;
	assign last_byte = byte_ok && (wpos_q == ADDR_W'(FRAME_LEN - 1));
	assign tick_act  = accept && (item.kind == KIND_TICK) && emit_q;
	assign bit_end   = tick_act && (phase_q == PHASE_W'(BIT_TICKS - 1));
	assign cell_end  = bit_end && (bit_q == BIT_W'(BITS_PER_CELL - 1));
	assign col_end   = (col_q == COL_W'(GRID_COLS - 1));
	assign last_cell = col_end && (row_q == ROW_W'(GRID_ROWS - 1));
	assign frame_end = cell_end && last_cell;
	assign next_load = cell_end && !last_cell;
	assign ram_we    = byte_ok;

	// serpentine walk: step within a row, jump by one row width at its end
	always_comb begin
		if (col_end) begin
			next_addr = addr_q + ADDR_W'(GRID_COLS);
		end else if (row_q[0]) begin
			next_addr = addr_q - ADDR_W'(1);
		end else begin
			next_addr = addr_q + ADDR_W'(1);
		end
	end

	assign ram_raddr = last_byte ? ADDR_W'(1) : next_addr;

	// data bit of the current cell word, green red blue, msb first
	always_comb begin
		en = palette(code_q);
		unique case (bit_q[4:3])
			CHAN_GREEN: chan_on = en.g;
			CHAN_RED:   chan_on = en.r;
			CHAN_BLUE:  chan_on = en.b;
			default:    chan_on = 1'b0;
		endcase
		data_bit = chan_on && cell_bright_q[~bit_q[2:0]];
	end

	// waveform level within one bit
	always_comb begin
		if (phase_q < PHASE_W'(HIGH_TICKS)) begin
			level = 1'b1;
		end else if (phase_q < PHASE_W'(HIGH_TICKS + DATA_TICKS)) begin
			level = data_bit;
		end else begin
			level = 1'b0;
		end
	end

	// result of the accepted transaction
	always_comb begin
		res              = '0;
		res.line_level   = tick_act && level;
		res.busy_res     = emit_q || last_byte;
		res.frame_done   = frame_end;
		res.byte_dropped = accept && (item.kind == KIND_BYTE) && emit_q;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= BRIGHTNESS_RESET;
			emit_q       <= 1'b0;
			wpos_q       <= '0;
			phase_q      <= '0;
			bit_q        <= '0;
			row_q        <= '0;
			col_q        <= '0;
			addr_q       <= '0;
			load_s1      <= 1'b0;
			fwd_s1       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				brightness_q <= cfg_wdata;
			end
			load_s1 <= last_byte || next_load;
			fwd_s1  <= ram_we && (wpos_q == ram_raddr);
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			// frame collection
			if (byte_ok) begin
				wpos_q <= last_byte ? '0 : wpos_q + ADDR_W'(1);
			end
			if (last_byte) begin
				emit_q  <= 1'b1;
				phase_q <= '0;
				bit_q   <= '0;
				row_q   <= '0;
				col_q   <= '0;
				addr_q  <= ADDR_W'(1);
			end
			// emission counters
			if (tick_act) begin
				phase_q <= bit_end ? '0 : phase_q + PHASE_W'(1);
			end
			if (bit_end) begin
				bit_q <= cell_end ? '0 : bit_q + BIT_W'(1);
			end
			if (frame_end) begin
				emit_q <= 1'b0;
			end
			if (next_load) begin
				addr_q <= next_addr;
				if (col_end) begin
					col_q <= '0;
					row_q <= row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		fwd_data_s1 <= item.frame_byte;
		if (last_byte || next_load) begin
			cell_bright_q <= brightness_q;
		end
		if (load_s1) begin
			code_q <= fwd_s1 ? fwd_data_s1 : ram_rdata;
		end
		if (accept) begin
			out_q <= res;
		end
	end

endmodule

@@ tb/led_line_checker.sv @@
`timescale 1ns / 100ps
// led_line_checker: watches the item, result and brightness ports of the led grid
// frame driver, predicts every result transaction and compares it field by field
// depends on lgfd_pkg
module led_line_checker
	import lgfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic       item_ready,
	input  item_t      item,
	input  logic       result_valid,
	input  logic       result_ready,
	input  result_t    result,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	output int         errors,
	output int         outstanding,
	output int         results_seen,
	output int         frames_seen,
	output int         drops_seen
);

	// predicted copy of the driver state
	logic [7:0]  cells [FRAME_LEN];
	logic [7:0]  level_cfg;
	int unsigned fill_pos;
	logic        playing;
	int unsigned cell_no;
	int unsigned bit_no;
	int unsigned tick_no;
	logic [23:0] grb_word;

	// line results predicted but not yet seen on the result port
	result_t     line_results_due [$];

	// grb word of the current cell, serpentine order, at the brightness in force now
	function automatic logic [23:0] cell_grb();
		int unsigned row;
		int unsigned col;
		logic [7:0]  g;
		logic [7:0]  r;
		logic [7:0]  b;
		row = cell_no / GRID_COLS;
		col = cell_no % GRID_COLS;
		if (row[0])
			col = GRID_COLS - 1 - col;
		g = '0;
		r = '0;
		b = '0;
		case (cells[row * GRID_COLS + col + 1])
			CODE_BLACK: ;
			CODE_RED:   r = level_cfg;
			CODE_GREEN: g = level_cfg;
			CODE_BLUE:  b = level_cfg;
			CODE_WHITE: begin
				r = level_cfg;
				g = level_cfg;
				b = level_cfg;
			end
			CODE_MAGENTA: begin
				r = level_cfg;
				b = level_cfg;
			end
			CODE_YELLOW: begin
				r = level_cfg;
				g = level_cfg;
			end
			CODE_CYAN: begin
				g = level_cfg;
				b = level_cfg;
			end
			default:    b = level_cfg;
		endcase
		return {g, r, b};
	endfunction

	// advance the predicted driver by one item and return the line result it causes
	function automatic result_t drive_line(input item_t it);
		result_t res;
		res = '0;
		if (it.kind == KIND_BYTE) begin
			if (playing) begin
				// byte while emitting is thrown away
				res.busy_res     = 1'b1;
				res.byte_dropped = 1'b1;
			end else begin
				cells[fill_pos] = it.frame_byte;
				fill_pos++;
				if (fill_pos >= FRAME_LEN) begin
					fill_pos = 0;
					playing  = 1'b1;
					cell_no  = 0;
					bit_no   = 0;
					tick_no  = 0;
					grb_word = cell_grb();
					res.busy_res = 1'b1;
				end
			end
		end else if (playing) begin
			res.busy_res = 1'b1;
			// high, then data, then low within each bit
			if (tick_no < HIGH_TICKS)
				res.line_level = 1'b1;
			else if (tick_no < HIGH_TICKS + DATA_TICKS)
				res.line_level = grb_word[23];
			tick_no++;
			if (tick_no >= BIT_TICKS) begin
				tick_no  = 0;
				grb_word = grb_word << 1;
				bit_no++;
				if (bit_no >= BITS_PER_CELL) begin
					bit_no = 0;
					cell_no++;
					if (cell_no >= CELL_COUNT) begin
						cell_no = 0;
						playing = 1'b0;
						res.frame_done = 1'b1;
					end else begin
						grb_word = cell_grb();
					end
				end
			end
		end
		return res;
	endfunction

	function automatic void check_field(input string field, input logic want, input logic got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %b actual %b", $time, field, want, got);
		end
	endfunction

	// track brightness writes, predict on item transactions, compare on result ones
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			level_cfg = BRIGHTNESS_RESET;
			fill_pos  = 0;
			playing   = 1'b0;
			cell_no   = 0;
			bit_no    = 0;
			tick_no   = 0;
			grb_word  = '0;
			line_results_due.delete();
		end else begin
			if (cfg_we)
				level_cfg = cfg_wdata;
			if (item_valid && item_ready)
				line_results_due.push_back(drive_line(item));
			if (result_valid && result_ready) begin
				if (line_results_due.size() == 0) begin
					errors++;
					$display("%0t: result with nothing expected, expected none actual %b",
						$time, result);
				end else begin
					want = line_results_due.pop_front();
					check_field("line_level", want.line_level, result.line_level);
					check_field("busy_res", want.busy_res, result.busy_res);
					check_field("frame_done", want.frame_done, result.frame_done);
					check_field("byte_dropped", want.byte_dropped, result.byte_dropped);
					results_seen++;
					if (want.frame_done)
						frames_seen++;
					if (want.byte_dropped)
						drops_seen++;
				end
			end
		end
		outstanding = line_results_due.size();
	end

endmodule

@@ tb/tb_led_grid_frame_driver.sv @@
`timescale 1ns / 100ps
// tb_led_grid_frame_driver: stimulus and verdict for the led grid frame driver
// depends on lgfd_pkg, led_grid_frame_driver and led_line_checker
module tb_led_grid_frame_driver;
	import lgfd_pkg::*;

	localparam int PLAY_TICKS  = 900;
	// the test sends about 1150 transactions
	localparam int CYCLE_LIMIT = 200_000;
	localparam int SEGMENTS    = 6;

	logic       clk;
	logic       arst_n;
	logic       item_valid;
	logic       item_ready;
	item_t      item;
	logic       result_valid;
	logic       result_ready;
	result_t    result;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	int errors;
	int outstanding;
	int results_seen;
	int frames_seen;
	int drops_seen;

	bit gaps_on;
	int stall_left;
	int cycles;

	led_grid_frame_driver uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	led_line_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.errors       (errors),
		.outstanding  (outstanding),
		.results_seen (results_seen),
		.frames_seen  (frames_seen),
		.drops_seen   (drops_seen)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// result side: random stall bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			result_ready <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 19) == 0) begin
			stall_left = $urandom_range(0, 14);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("led_grid_frame_driver: mismatch");
			$finish;
		end
	end

	// offer one item, with an occasional idle burst first, and wait for its transaction
	task automatic send_item(input logic kind, input logic [7:0] value);
		logic taken;
		if (gaps_on && $urandom_range(0, 19) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= '{kind: kind, frame_byte: value};
		do begin
			@(negedge clk);
			taken = item_ready;
			@(posedge clk);
		end while (!taken);
	endtask

	// hold off until every predicted result has come back
	task automatic drain();
		item_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_brightness(input logic [7:0] value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// store frame bytes, mostly palette codes, with ignored ticks in between
	task automatic fill_frame(input int count);
		logic [7:0] code;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_item(KIND_TICK, 8'($urandom_range(0, 255)));
			if ($urandom_range(0, 3) != 0)
				code = 8'($urandom_range(0, 8));
			else
				code = 8'($urandom_range(0, 255));
			send_item(KIND_BYTE, code);
		end
	endtask

	// tick the waveform along, with stray bytes that must be dropped
	task automatic play_ticks(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 39) == 0)
				send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
			send_item(KIND_TICK, 8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		result_ready = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		gaps_on      = 1'b1;
		stall_left   = 0;
		cycles       = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ticks while idle, dummy byte, every palette code and the byte extremes
		send_item(KIND_TICK, 8'h00);
		send_item(KIND_TICK, 8'hff);
		send_item(KIND_BYTE, 8'hff);
		send_item(KIND_BYTE, CODE_BLACK);
		send_item(KIND_BYTE, CODE_RED);
		send_item(KIND_BYTE, CODE_GREEN);
		send_item(KIND_BYTE, CODE_BLUE);
		send_item(KIND_BYTE, CODE_WHITE);
		send_item(KIND_BYTE, CODE_MAGENTA);
		send_item(KIND_BYTE, CODE_YELLOW);
		send_item(KIND_BYTE, CODE_CYAN);
		send_item(KIND_BYTE, 8'd8);
		send_item(KIND_BYTE, 8'hff);
		send_item(KIND_BYTE, 8'h80);
		send_item(KIND_BYTE, 8'h00);
		send_item(KIND_TICK, 8'h00);

		// frame at reset brightness, changed between segments of the playout,
		// no idling in the last segment
		fill_frame(FRAME_LEN - 13);
		for (int s = 0; s < SEGMENTS; s++) begin
			if (s == SEGMENTS - 1)
				gaps_on = 1'b0;
			play_ticks(PLAY_TICKS / SEGMENTS);
			if (s < SEGMENTS - 1) begin
				case (s)
					0:       write_brightness(8'd255);
					1:       write_brightness(8'd0);
					2:       write_brightness(8'($urandom_range(2, 254)));
					3:       write_brightness(8'd1);
					default: write_brightness(8'd128);
				endcase
			end
		end
		send_item(KIND_TICK, 8'h00);
		send_item(KIND_BYTE, 8'h00);

		drain();
		repeat (20) @(posedge clk);
		$display("covered %0d results over the first cells of a frame, %0d bytes dropped",
			results_seen, drops_seen);
		$display("brightness rewritten between playout segments while the frame was busy");
		if (errors == 0 && outstanding == 0) begin
			$display("led_grid_frame_driver: match");
		end else begin
			$display("led_grid_frame_driver: mismatch");
		end
		$finish;
	end

endmodule

@@ files.f @@
hdl/lgfd_pkg.sv
hdl/lgfd_ram.sv
hdl/led_grid_frame_driver.sv
tb/led_line_checker.sv
tb/tb_led_grid_frame_driver.sv
